### sv/q8_block_dequantizer_assert.svh
// Assertion macros for the Q8_0 block dequantizer.
// Used by q8_block_dequantizer.sv; no other dependencies.
`ifndef Q8_BLOCK_DEQUANTIZER_ASSERT_SVH
`define Q8_BLOCK_DEQUANTIZER_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define Q8_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
// Next-cycle implication checked outside reset.
`define Q8_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`endif

### sv/q8d_pkg.sv
// Package for the Q8_0 block dequantizer: widths and float constants.
// No dependencies.
package q8d_pkg;
	localparam int unsigned BLOCK_ELEMENTS = 32;
	localparam int unsigned POS_W = 6;
	localparam int unsigned IDX_W = 5;
	localparam logic [31:0] F32_INF = 32'h7f80_0000;
	localparam logic [31:0] F32_QNAN = 32'h7fc0_0000;
	localparam logic [31:0] F32_QBIT = 32'h0040_0000;
	typedef logic [31:0] f32_t;
endpackage

### sv/q8_block_dequantizer.sv
// Q8_0 block dequantizer top level: byte stream in, float32 words out.
// Depends on q8d_pkg and q8_block_dequantizer_assert.svh.
//
// The block takes one byte word per cycle on the s_axis side unless an m_axis
// stall fills both registers. Every block is BLOCK_ELEMENTS + 2 bytes: a
// little-endian FP16 scale, then signed quants. Each quant yields one
// float32 word, scale * q, exact with no rounding, on m_axis along with its
// element index (tuser) and tlast on the last element. Scale bytes yield no
// word. A quant goes through the input register, then the result register.
// The input stage is refilled whenever the result register is empty or being
// drained, so back-to-back streaming runs without bubbles. NaN scales pass
// through widened and quieted, inf * 0 gives the default quiet NaN, and a
// zero product carries the xor of the operand signs.
`include "q8_block_dequantizer_assert.svh"
module q8_block_dequantizer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] block_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,   // [31:0] value_bits
	output logic [4:0]  m_axis_tuser,   // [4:0] element_index
	output logic        m_axis_tlast    // block_last
);
	import q8d_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(BLOCK_ELEMENTS + 1);

	// ---- byte position tracker and scale capture (input side)
	logic [POS_W-1:0] pos_q;
	logic [7:0]       scale_lo_q;
	logic [15:0]      scale_q;

	// ---- stage 1: one quant with the scale it belongs to
	logic             vld_s1;
	logic [7:0]       q_s1;
	logic [15:0]      h_s1;
	logic [IDX_W-1:0] idx_s1;
	logic             last_s1;

	// ---- stage 2: result word
	logic             vld_s2;
	f32_t             val_s2;
	logic [IDX_W-1:0] idx_s2;
	logic             last_s2;

	logic adv_s2, adv_s1, acc, is_quant;

	assign adv_s2 = !vld_s2 || m_axis_tready;
	assign adv_s1 = !vld_s1 || adv_s2;
	assign s_axis_tready = adv_s1;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign is_quant = (pos_q > POS_W'(1)) && (pos_q <= LAST_POS);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			scale_lo_q <= '0;
			scale_q <= '0;
		end else if (acc) begin
			// Treat any out-of-range position as the start of a block.
			if (pos_q == '0 || pos_q > LAST_POS) begin
				scale_lo_q <= s_axis_tdata;
				pos_q <= POS_W'(1);
			end else if (pos_q == POS_W'(1)) begin
				scale_q <= {s_axis_tdata, scale_lo_q};
				pos_q <= POS_W'(2);
			end else begin
				pos_q <= (pos_q == LAST_POS) ? '0 : pos_q + POS_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv_s1) begin
			vld_s1 <= acc && is_quant;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			q_s1 <= s_axis_tdata;
			h_s1 <= scale_q;
			idx_s1 <= IDX_W'(pos_q - POS_W'(2));
			last_s1 <= (pos_q == LAST_POS);
		end
	end

	// ---- float product: 11x7 multiply, then leading-one normalize
	logic        hs, qn;
	logic [4:0]  he;
	logic [9:0]  hm;
	logic [6:0]  qmag;
	logic [10:0] mant;
	logic [17:0] prod;
	logic [4:0]  lead;
	logic [7:0]  fexp;
	logic [22:0] frac;
	logic [40:0] shl;
	f32_t        res;

	always_comb begin
		hs = h_s1[15];
		he = h_s1[14:10];
		hm = h_s1[9:0];
		qn = q_s1[7];
		// |q| fits 8 bits only at -128; handle as 7-bit magnitude plus flag.
		qmag = qn ? 7'(~q_s1 + 8'd1) : q_s1[6:0];
		mant = (he == 5'd0) ? {1'b0, hm} : {1'b1, hm};
		prod = (qn && qmag == 7'd0) ? {mant, 7'd0} : 18'(mant * qmag);
		lead = '0;
		for (int i = 1; i < 18; i++) begin
			if (prod[i]) lead = 5'(i);
		end
		// exponent: lead + (he==0 ? -24 : he-25) + 127
		fexp = (he == 5'd0) ? 8'(lead + 8'd103) : 8'(lead + he + 8'd102);
		shl = 41'(prod) << (5'd23 - lead);
		frac = shl[22:0];
		if (he == 5'h1f) begin
			if (hm != '0) res = {hs, 31'(F32_INF)} | {9'd0, hm, 13'd0} | F32_QBIT;
			else if (q_s1 == '0) res = F32_QNAN;
			else res = {hs ^ qn, 31'(F32_INF)};
		end else if ((he == '0 && hm == '0) || q_s1 == '0) begin
			res = {hs ^ qn, 31'd0};
		end else begin
			res = {hs ^ qn, fexp, frac};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else if (adv_s2) begin
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			val_s2 <= res;
			idx_s2 <= idx_s1;
			last_s2 <= last_s1;
		end
	end

	assign m_axis_tvalid = vld_s2;
	assign m_axis_tdata = val_s2;
	assign m_axis_tuser = idx_s2;
	assign m_axis_tlast = last_s2;

	`Q8_ASSERT_IMP(a_last_idx, vld_s2 && last_s2, idx_s2 == IDX_W'(BLOCK_ELEMENTS - 1),
		"tlast without final element index")
	`Q8_ASSERT_IMP(a_pos_range, 1'b1, pos_q <= LAST_POS, "byte position out of range")
	`Q8_ASSERT_NEXT(a_stall_hold, vld_s2 && !m_axis_tready, vld_s2 && $stable(val_s2),
		"result changed while stalled")
	`Q8_ASSERT_NEXT(a_scale_no_out, acc && pos_q < POS_W'(2), !vld_s1,
		"scale byte produced a result")
endmodule

### dv/tb.sv
// Testbench for q8_block_dequantizer: drives Q8_0 block bytes, predicts each
// float32 word in-line and checks it. Depends on q8d_pkg and the block RTL.
`timescale 1ns / 100ps
module tb;
	import q8d_pkg::*;

	localparam int BLK_BYTES = 34;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] block_byte
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [31:0] m_axis_tdata;   // [31:0] value_bits
	logic [4:0]  m_axis_tuser;   // [4:0] element_index
	logic        m_axis_tlast;   // block_last

	typedef struct packed {
		f32_t             value;
		logic [IDX_W-1:0] index;
		logic             last;
	} deq_word_t;

	deq_word_t    pending_words[$];
	logic [5:0]   byte_pos;
	logic [7:0]   scale_lo;
	logic [15:0]  scale_fp16;
	int           mismatches;

	q8_block_dequantizer i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
		.m_axis_tlast(m_axis_tlast)
	);

	always #5 clk = ~clk;

	// Exact fp16 * int8 product as float32 bits; integer multiply, then normalize.
	function automatic f32_t scale_times_quant(logic [15:0] h, logic [7:0] q);
		logic        hs, qneg, sgn;
		logic [4:0]  he;
		logic [9:0]  hm;
		logic [7:0]  qmag;
		logic [31:0] mant, prod;
		int          e2, lead;
		hs = h[15];
		he = h[14:10];
		hm = h[9:0];
		qneg = q[7];
		qmag = qneg ? 8'(-q) : q;
		sgn = hs ^ qneg;
		if (he == 5'h1f) begin
			if (hm != 0)
				return {hs, 31'h0} | F32_INF | ({22'h0, hm} << 13) | F32_QBIT;
			if (qmag == 0)
				return F32_QNAN;
			return {sgn, 31'h0} | F32_INF;
		end
		if ((he == 0 && hm == 0) || qmag == 0)
			return {sgn, 31'h0};
		if (he == 0) begin
			mant = {22'h0, hm};
			e2 = -24;
		end else begin
			mant = {21'h0, 1'b1, hm};
			e2 = int'(he) - 25;
		end
		prod = mant * {24'h0, qmag};
		lead = 0;
		while (lead < 31 && (prod >> (lead + 1)) != 0)
			lead++;
		return {sgn, 8'(lead + e2 + 127), 23'((prod << (23 - lead)) & 32'h7fffff)};
	endfunction

	// Advance the predictor by one accepted byte word.
	task automatic predict_byte(logic [7:0] b);
		deq_word_t w;
		int        pos;
		pos = (byte_pos >= BLK_BYTES) ? 0 : int'(byte_pos);
		if (pos == 0) begin
			scale_lo = b;
			byte_pos = 6'd1;
		end else if (pos == 1) begin
			scale_fp16 = {b, scale_lo};
			byte_pos = 6'd2;
		end else begin
			w.value = scale_times_quant(scale_fp16, b);
			w.index = IDX_W'(pos - 2);
			w.last = (pos - 2 == 31);
			pending_words.push_back(w);
			byte_pos = (pos + 1 >= BLK_BYTES) ? 6'd0 : 6'(pos + 1);
		end
	endtask

	function automatic int gap_len();
		if ($urandom_range(0, 99) < 60)
			return 0;
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Send one byte word; gaps hold tvalid low first when enabled.
	bit gaps_on;
	task automatic send_byte(logic [7:0] b);
		int g;
		g = gaps_on ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_byte(b);
	endtask

	task automatic send_block(logic [15:0] scale, bit rand_q, logic [7:0] q_fixed);
		send_byte(scale[7:0]);
		send_byte(scale[15:8]);
		for (int i = 0; i < 32; i++)
			send_byte(rand_q ? 8'($urandom_range(0, 255)) : q_fixed);
	endtask

	task automatic idle_input();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	// Directed: extreme quants and every special scale class.
	task automatic test_directed_scales();
		logic [7:0] quants[6];
		quants = '{8'h00, 8'h01, 8'h7f, 8'h80, 8'hff, 8'h55};
		send_byte(8'h00);   // scale 1.0
		send_byte(8'h3c);
		foreach (quants[i])
			send_byte(quants[i]);
		for (int i = 6; i < 32; i++)
			send_byte(8'(i * 37));
		send_block(16'h7e01, 1'b1, 8'h00);   // NaN payload
		send_block(16'hfc00, 1'b0, 8'h00);   // -inf times zero
		send_block(16'h8000, 1'b1, 8'h00);   // negative zero scale
		send_block(16'h0001, 1'b1, 8'h00);   // smallest subnormal
		send_block(16'hfbff, 1'b1, 8'h00);   // largest finite, negative
		send_block(16'h7c00, 1'b1, 8'h00);   // +inf with mixed quants
	endtask

	// Hold input until every expected word has come back.
	task automatic test_drain_pause();
		idle_input();
		while (pending_words.size() != 0)
			@(posedge clk);
		send_block(16'h03ff, 1'b1, 8'h00);
	endtask

	// Random: mostly finite scales, some special ones, all quants random.
	task automatic test_random_blocks();
		logic [15:0] sc;
		for (int n = 0; n < 23; n++) begin
			sc = 16'($urandom_range(0, 16'hffff));
			if ($urandom_range(0, 9) == 0)
				sc[14:10] = 5'h1f;
			else if ($urandom_range(0, 9) == 0)
				sc[14:10] = 5'h00;
			gaps_on = (n % 5 != 4);
			send_block(sc, 1'b1, 8'h00);
		end
		gaps_on = 1'b1;
	endtask

	// Receiver stalls and checking.
	int rx_stall;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			rx_stall <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				deq_word_t exp_w;
				if (pending_words.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("unexpected word %h idx %0d", m_axis_tdata, m_axis_tuser);
				end else begin
					exp_w = pending_words.pop_front();
					if (exp_w.value !== m_axis_tdata || exp_w.index !== m_axis_tuser
							|| exp_w.last !== m_axis_tlast) begin
						mismatches++;
						if (mismatches <= 10)
							$display("mismatch: exp %h/%0d/%b got %h/%0d/%b",
								exp_w.value, exp_w.index, exp_w.last,
								m_axis_tdata, m_axis_tuser, m_axis_tlast);
					end
				end
			end
			if (rx_stall > 0) begin
				rx_stall <= rx_stall - 1;
				m_axis_tready <= 1'b0;
			end else if (gaps_on && gap_len() > 0) begin
				rx_stall <= gap_len();
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	initial begin
		#5_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = 8'h00;
		byte_pos = '0;
		scale_lo = '0;
		scale_fp16 = '0;
		mismatches = 0;
		gaps_on = 1'b1;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_scales();
		test_drain_pause();
		test_random_blocks();
		idle_input();
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
